// ----- design/tiir_pkg.sv -----
package tiir_pkg;

  // Sample and coefficient formats
  localparam int SAMPLE_W   = 32;
  localparam int COEF_W     = 32;
  localparam int FRAC_SHIFT = 30;
  localparam int PROD_W     = SAMPLE_W + COEF_W;
  localparam int ACC_W      = PROD_W + 3;

  // Filter shape
  localparam int FF_TAPS    = 4;
  localparam int NUM_TAPS   = 7;
  localparam int RING_DEPTH = 4;
  localparam int SLOT_W     = 2;
  localparam int STEP_W     = 3;
  localparam int NUM_FIELDS = 3;
  localparam int AXES_DEF   = 3;

  localparam logic [STEP_W-1:0] LAST_STEP = STEP_W'(NUM_TAPS);

  // Configuration port
  localparam int CFG_IDX_W  = 3;
  localparam logic [CFG_IDX_W-1:0] CFG_FF_TAP0 = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_FF_TAP1 = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_FF_TAP2 = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_FF_TAP3 = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_FB_TAP1 = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_FB_TAP2 = 3'd5;
  localparam logic [CFG_IDX_W-1:0] CFG_FB_TAP3 = 3'd6;

  // Reset coefficients, in register index order
  localparam logic signed [COEF_W-1:0] TAP_RESET [NUM_TAPS] = '{
    32'sd20331301,
    32'sd60993904,
    32'sd60993904,
    32'sd20331301,
    -32'sd1866506888,
    32'sd1246925643,
    -32'sd291510168
  };

  localparam logic signed [ACC_W-1:0] ROUND_HALF = ACC_W'(1 << (FRAC_SHIFT - 1));
  localparam logic signed [SAMPLE_W-1:0] SAT_MAX = {1'b0, {(SAMPLE_W-1){1'b1}}};
  localparam logic signed [SAMPLE_W-1:0] SAT_MIN = {1'b1, {(SAMPLE_W-1){1'b0}}};

  // Sequencer to lane controls, shared by all lanes
  typedef struct packed {
    logic                       wr_in;
    logic [SLOT_W-1:0]          wr_slot;
    logic                       mac;
    logic                       acc_en;
    logic                       first;
    logic [SLOT_W-1:0]          rd_idx;
    logic                       rd_out;
    logic                       sub;
    logic signed [COEF_W-1:0]   coef;
    logic                       fin;
    logic [SLOT_W-1:0]          fin_slot;
  } tiir_ctrl_t;

endpackage

// ----- design/tiir_in_if.sv -----
interface tiir_in_if;
  import tiir_pkg::*;

  logic                       valid;
  logic                       ready;
  logic signed [SAMPLE_W-1:0] err_x;
  logic signed [SAMPLE_W-1:0] err_y;
  logic signed [SAMPLE_W-1:0] err_z;

  modport source (output valid, output err_x, output err_y, output err_z, input ready);
  modport sink (input valid, input err_x, input err_y, input err_z, output ready);
endinterface

// ----- design/tiir_out_if.sv -----
interface tiir_out_if;
  import tiir_pkg::*;

  logic                       valid;
  logic                       ready;
  logic signed [SAMPLE_W-1:0] filt_x;
  logic signed [SAMPLE_W-1:0] filt_y;
  logic signed [SAMPLE_W-1:0] filt_z;

  modport source (output valid, output filt_x, output filt_y, output filt_z, input ready);
  modport sink (input valid, input filt_x, input filt_y, input filt_z, output ready);
endinterface

// ----- design/tiir_ctrl.sv -----
module tiir_ctrl (
  input  logic                                   clk,
  input  logic                                   rst_n,
  input  logic                                   in_valid,
  output logic                                   in_ready,
  input  logic                                   out_valid,
  input  logic                                   out_ready,
  input  logic                                   cfg_we,
  input  logic [tiir_pkg::CFG_IDX_W-1:0]         cfg_idx,
  input  logic [tiir_pkg::COEF_W-1:0]            cfg_wdata,
  output tiir_pkg::tiir_ctrl_t                   ctrl
);
  import tiir_pkg::*;

  logic signed [COEF_W-1:0] coef_r [NUM_TAPS];
  logic                     busy_r, busy_nxt;
  logic [STEP_W-1:0]        step_r, step_nxt;
  logic [SLOT_W-1:0]        ring_slot_r, ring_slot_nxt;
  logic [SLOT_W-1:0]        cur_slot_r, cur_slot_nxt;
  logic                     accept;
  logic                     fin;
  logic [SLOT_W-1:0]        tap_k;

  // Coefficient registers; writes past the last tap are dropped
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < NUM_TAPS; i++) coef_r[i] <= TAP_RESET[i];
    end else if (cfg_we && cfg_idx <= CFG_FB_TAP3) begin
      coef_r[cfg_idx] <= $signed(cfg_wdata);
    end
  end

  // Finish the beat once the output register can take it
  assign fin      = busy_r && (step_r == LAST_STEP) && (!out_valid || out_ready);
  assign in_ready = !busy_r || fin;
  assign accept   = in_valid && in_ready;

  always_comb begin
    busy_nxt      = busy_r;
    step_nxt      = step_r;
    ring_slot_nxt = ring_slot_r;
    cur_slot_nxt  = cur_slot_r;
    if (accept) begin
      busy_nxt      = 1'b1;
      step_nxt      = '0;
      cur_slot_nxt  = ring_slot_r;
      ring_slot_nxt = ring_slot_r + SLOT_W'(1);
    end else if (fin) begin
      busy_nxt = 1'b0;
    end else if (busy_r && step_r != LAST_STEP) begin
      step_nxt = step_r + STEP_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r      <= 1'b0;
      step_r      <= '0;
      ring_slot_r <= '0;
      cur_slot_r  <= '0;
    end else begin
      busy_r      <= busy_nxt;
      step_r      <= step_nxt;
      ring_slot_r <= ring_slot_nxt;
      cur_slot_r  <= cur_slot_nxt;
    end
  end

  // Tap distance: feedforward steps look 0..3 back, feedback steps 1..3 back
  assign tap_k = (step_r < STEP_W'(FF_TAPS)) ? step_r[SLOT_W-1:0]
                                             : SLOT_W'(step_r - STEP_W'(FF_TAPS - 1));

  always_comb begin
    ctrl.wr_in    = accept;
    ctrl.wr_slot  = ring_slot_r;
    ctrl.mac      = busy_r && (step_r < LAST_STEP);
    ctrl.acc_en   = busy_r && (step_r != '0) && (step_r < LAST_STEP);
    ctrl.first    = (step_r == STEP_W'(1));
    ctrl.rd_idx   = cur_slot_r - tap_k;
    ctrl.rd_out   = (step_r >= STEP_W'(FF_TAPS));
    ctrl.sub      = (step_r >= STEP_W'(FF_TAPS));
    ctrl.coef     = (step_r < LAST_STEP) ? coef_r[step_r] : '0;
    ctrl.fin      = fin;
    ctrl.fin_slot = cur_slot_r;
  end

endmodule

// ----- design/tiir_lane.sv -----
module tiir_lane (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  tiir_pkg::tiir_ctrl_t                 ctrl,
  input  logic signed [tiir_pkg::SAMPLE_W-1:0] x_in,
  output logic signed [tiir_pkg::SAMPLE_W-1:0] y_out
);
  import tiir_pkg::*;

  logic signed [SAMPLE_W-1:0] xh_r [RING_DEPTH];
  logic signed [SAMPLE_W-1:0] yh_r [RING_DEPTH];
  logic signed [SAMPLE_W-1:0] hist_sel;
  logic signed [PROD_W-1:0]   prod_w, prod_r;
  logic                       sub_r;
  logic signed [ACC_W-1:0]    acc_r, acc_nxt;
  logic signed [ACC_W-1:0]    term_w, sum_w, shifted_w;
  logic [ACC_W-SAMPLE_W:0]    hi_bits;
  logic                       ovf;

  // History rings: input at accept, saturated output at finish
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < RING_DEPTH; i++) begin
        xh_r[i] <= '0;
        yh_r[i] <= '0;
      end
    end else begin
      if (ctrl.wr_in) xh_r[ctrl.wr_slot] <= x_in;
      if (ctrl.fin) yh_r[ctrl.fin_slot] <= y_out;
    end
  end

  // One product per step, registered before the accumulate
  assign hist_sel = ctrl.rd_out ? yh_r[ctrl.rd_idx] : xh_r[ctrl.rd_idx];
  assign prod_w   = PROD_W'(ctrl.coef) * PROD_W'(hist_sel);

  always_ff @(posedge clk) begin
    if (ctrl.mac) begin
      prod_r <= prod_w;
      sub_r  <= ctrl.sub;
    end
  end

  // Accumulate; the rounding half is folded in with the first product
  assign term_w  = sub_r ? -ACC_W'(prod_r) : ACC_W'(prod_r);
  assign acc_nxt = (ctrl.first ? ROUND_HALF : acc_r) + term_w;

  always_ff @(posedge clk) begin
    if (ctrl.acc_en) acc_r <= acc_nxt;
  end

  // Last product, drop the fraction, clamp to the sample range
  assign sum_w     = acc_r + term_w;
  assign shifted_w = sum_w >>> FRAC_SHIFT;
  assign hi_bits   = shifted_w[ACC_W-1:SAMPLE_W-1];
  assign ovf       = !((&hi_bits) || !(|hi_bits));
  assign y_out     = ovf ? (shifted_w[ACC_W-1] ? SAT_MIN : SAT_MAX)
                         : shifted_w[SAMPLE_W-1:0];

endmodule

// ----- design/tiir_merge.sv -----
module tiir_merge #(
  parameter int AXES = tiir_pkg::AXES_DEF
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 fin,
  input  logic signed [tiir_pkg::SAMPLE_W-1:0] lane_res [AXES],
  input  logic                                 out_ready,
  output logic                                 out_valid,
  output logic signed [tiir_pkg::SAMPLE_W-1:0] fields [tiir_pkg::NUM_FIELDS]
);
  import tiir_pkg::*;

  logic                       valid_r, valid_nxt;
  logic signed [SAMPLE_W-1:0] data_r [AXES];

  // Hold the result beat until taken
  always_comb begin
    valid_nxt = valid_r;
    if (fin) valid_nxt = 1'b1;
    else if (out_ready) valid_nxt = 1'b0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) valid_r <= 1'b0;
    else valid_r <= valid_nxt;
  end

  always_ff @(posedge clk) begin
    if (fin) begin
      for (int a = 0; a < AXES; a++) data_r[a] <= lane_res[a];
    end
  end

  assign out_valid = valid_r;

  // Fields without a lane read as zero
  for (genvar f = 0; f < NUM_FIELDS; f++) begin : g_field
    if (f < AXES) begin : g_lane
      assign fields[f] = data_r[f];
    end else begin : g_zero
      assign fields[f] = '0;
    end
  end

endmodule

// ----- design/third_order_iir_xyz_filter_core.sv -----
// Three-axis third-order IIR filter, direct form I. Each input beat carries one
// signed Q16.16 error sample per axis; each result beat carries one filtered,
// saturated Q16.16 value per axis. Coefficients are signed Q2.30 and may be
// rewritten at any time the block is idle through the cfg port (index 0..3 are
// the feedforward taps b0..b3, 4..6 the feedback taps a1..a3; other indexes are
// ignored). Every axis has its own lane with one 32x32 multiplier that runs the
// seven taps in turn. A new item is taken in the cycle its predecessor finishes,
// not before: the serial multiply-accumulate in each lane sets the pace. A
// finished result waits in an output register without blocking the next item;
// only when that register is still full at the end of the next item does the
// lane hold. Histories reset to zero with rst_n.
module third_order_iir_xyz_filter_core #(
  parameter int AXES = tiir_pkg::AXES_DEF
) (
  input  logic                             clk,
  input  logic                             rst_n,
  tiir_in_if.sink                          in_ch,
  tiir_out_if.source                       out_ch,
  input  logic                             cfg_we,
  input  logic [tiir_pkg::CFG_IDX_W-1:0]   cfg_idx,
  input  logic [tiir_pkg::COEF_W-1:0]      cfg_wdata
);
  import tiir_pkg::*;

  tiir_ctrl_t                 ctrl;
  logic                       out_valid;
  logic signed [SAMPLE_W-1:0] in_fields [NUM_FIELDS];
  logic signed [SAMPLE_W-1:0] lane_res [AXES];
  logic signed [SAMPLE_W-1:0] out_fields [NUM_FIELDS];

  tiir_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ch.ready),
    .out_valid (out_valid),
    .out_ready (out_ch.ready),
    .cfg_we    (cfg_we),
    .cfg_idx   (cfg_idx),
    .cfg_wdata (cfg_wdata),
    .ctrl      (ctrl)
  );

  assign in_fields[0] = in_ch.err_x;
  assign in_fields[1] = in_ch.err_y;
  assign in_fields[2] = in_ch.err_z;

  // One lane per axis; lanes past the input fields see zero
  for (genvar a = 0; a < AXES; a++) begin : g_lane
    logic signed [SAMPLE_W-1:0] x_lane;
    if (a < NUM_FIELDS) begin : g_in
      assign x_lane = in_fields[a];
    end else begin : g_zero
      assign x_lane = '0;
    end

    tiir_lane u_lane (
      .clk   (clk),
      .rst_n (rst_n),
      .ctrl  (ctrl),
      .x_in  (x_lane),
      .y_out (lane_res[a])
    );
  end

  tiir_merge #(.AXES(AXES)) u_merge (
    .clk       (clk),
    .rst_n     (rst_n),
    .fin       (ctrl.fin),
    .lane_res  (lane_res),
    .out_ready (out_ch.ready),
    .out_valid (out_valid),
    .fields    (out_fields)
  );

  assign out_ch.valid  = out_valid;
  assign out_ch.filt_x = out_fields[0];
  assign out_ch.filt_y = out_fields[1];
  assign out_ch.filt_z = out_fields[2];

endmodule

// ----- design/tiir_checker.sv -----
module tiir_checker (
  input logic clk,
  input logic rst_n,
  input logic in_valid,
  input logic in_ready,
  input logic out_valid,
  input logic out_ready
);

  // A result beat stays until taken
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result beat dropped before it was taken");

  // The lanes stay busy for the multiply-accumulate steps after an accept
  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready ##6 !in_ready)
    else $error("input taken while the lanes were still working");

  // A fresh result beat never rises without an accepted input behind it
  a_no_phantom: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(in_valid && in_ready, 9))
    else $error("result beat without a matching input");

  // The lanes never accept twice in a row
  a_no_double: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !(in_valid && in_ready))
    else $error("two inputs accepted on consecutive edges");

endmodule

bind third_order_iir_xyz_filter_core tiir_checker u_tiir_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_ch.valid),
  .in_ready  (in_ch.ready),
  .out_valid (out_ch.valid),
  .out_ready (out_ch.ready)
);

// ----- sim/filt_xyz_check.sv -----
module filt_xyz_check
  import tiir_pkg::*;
#(
  parameter int AXES = AXES_DEF
) (
  input  logic                 clk,
  input  logic                 rst_n,
  tiir_in_if                   in_ch,
  tiir_out_if                  out_ch,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_idx,
  input  logic [COEF_W-1:0]    cfg_wdata,
  output int                   mismatch_count,
  output int                   filt_outstanding,
  output int                   filt_checked
);

  typedef logic signed [SAMPLE_W-1:0] sample_t;
  typedef logic signed [COEF_W-1:0]   coef_t;
  typedef logic signed [PROD_W-1:0]   prod_t;
  typedef logic signed [ACC_W-1:0]    acc_t;

  typedef struct packed {
    sample_t filt_x;
    sample_t filt_y;
    sample_t filt_z;
  } filt_t;

  // Own copy of the tap registers (register index order) and the per-axis rings
  coef_t             tap_coef [NUM_TAPS];
  sample_t           err_ring [AXES][RING_DEPTH];
  sample_t           filt_ring [AXES][RING_DEPTH];
  logic [SLOT_W-1:0] wr_slot;
  filt_t             pending_filt_q [$];

  // Run one axis through the direct-form-I sum and update its rings
  function automatic sample_t filter_lane(int lane, sample_t err);
    acc_t              acc;
    prod_t             prod;
    logic [SLOT_W-1:0] rd;
    sample_t           y;
    int                k;
    acc = '0;
    err_ring[lane][wr_slot] = err;
    // Feedforward on the newest sample and three back; the slot four back stays out
    for (k = 0; k < FF_TAPS; k++) begin
      rd   = wr_slot - SLOT_W'(k);
      prod = prod_t'(tap_coef[k]) * prod_t'(err_ring[lane][rd]);
      acc  = acc + acc_t'(prod);
    end
    // Subtract feedback on the past outputs
    for (k = 1; k < RING_DEPTH; k++) begin
      rd   = wr_slot - SLOT_W'(k);
      prod = prod_t'(tap_coef[FF_TAPS + k - 1]) * prod_t'(filt_ring[lane][rd]);
      acc  = acc - acc_t'(prod);
    end
    // Round to Q16.16 with ties upward, then clamp to 32 bits
    acc = (acc + ROUND_HALF) >>> FRAC_SHIFT;
    if (acc > acc_t'(SAT_MAX)) begin
      y = SAT_MAX;
    end else if (acc < acc_t'(SAT_MIN)) begin
      y = SAT_MIN;
    end else begin
      y = sample_t'(acc);
    end
    filt_ring[lane][wr_slot] = y;
    return y;
  endfunction

  // Filter one three-axis sample; lanes without a field see zero, fields without a lane read zero
  function automatic filt_t predict_filt(sample_t ex, sample_t ey, sample_t ez);
    sample_t err_in [NUM_FIELDS];
    sample_t filt_out [NUM_FIELDS];
    sample_t y;
    int      a;
    err_in   = '{ex, ey, ez};
    filt_out = '{default: '0};
    for (a = 0; a < AXES; a++) begin
      y = filter_lane(a, (a < NUM_FIELDS) ? err_in[a] : sample_t'(0));
      if (a < NUM_FIELDS) begin
        filt_out[a] = y;
      end
    end
    wr_slot = wr_slot + SLOT_W'(1);
    return '{filt_out[0], filt_out[1], filt_out[2]};
  endfunction

  function automatic void check_field(string name, sample_t want, sample_t got);
    if (got !== want) begin
      $error("%s mismatch: expected %0d, got %0d", name, want, got);
      mismatch_count++;
    end
  endfunction

  // Track config writes, compare result beats, queue predictions for input beats
  always @(posedge clk) begin
    filt_t want;
    if (!rst_n) begin
      foreach (tap_coef[i]) tap_coef[i] = TAP_RESET[i];
      err_ring  = '{default: '0};
      filt_ring = '{default: '0};
      wr_slot   = '0;
      pending_filt_q.delete();
    end else begin
      // Drop writes to indexes past the last tap
      if (cfg_we && cfg_idx < NUM_TAPS) begin
        tap_coef[cfg_idx] = coef_t'(cfg_wdata);
      end
      if (out_ch.valid && out_ch.ready) begin
        if (pending_filt_q.size() == 0) begin
          $error("result beat with nothing pending: filt_x=%0d filt_y=%0d filt_z=%0d",
                 out_ch.filt_x, out_ch.filt_y, out_ch.filt_z);
          mismatch_count++;
        end else begin
          want = pending_filt_q.pop_front();
          check_field("filt_x", want.filt_x, out_ch.filt_x);
          check_field("filt_y", want.filt_y, out_ch.filt_y);
          check_field("filt_z", want.filt_z, out_ch.filt_z);
          filt_checked++;
        end
      end
      if (in_ch.valid && in_ch.ready) begin
        pending_filt_q.push_back(predict_filt(in_ch.err_x, in_ch.err_y, in_ch.err_z));
      end
    end
    filt_outstanding = pending_filt_q.size();
  end

endmodule

// ----- sim/third_order_iir_xyz_filter_core_tb.sv -----
module third_order_iir_xyz_filter_core_tb;
  import tiir_pkg::*;

  typedef logic signed [SAMPLE_W-1:0] sample_t;
  typedef logic signed [COEF_W-1:0]   coef_t;

  typedef enum int {IDLE_NONE, IDLE_SEND, IDLE_RECV, IDLE_BOTH} idle_mode_e;
  typedef enum int {COEF_DEFAULT, COEF_STABLE, COEF_RANDOM, COEF_EXTREME} coef_set_e;

  localparam logic [CFG_IDX_W-1:0] CFG_IDX_UNUSED = 3'd7;
  localparam coef_t   COEF_MAX        = 32'sh7FFF_FFFF;
  localparam coef_t   COEF_MIN        = 32'sh8000_0000;
  localparam coef_t   COEF_ONE        = 32'sh4000_0000;
  localparam int      CLK_HALF        = 10;
  localparam int      RESET_CYCLES    = 9;
  localparam int      PHASES          = 8;
  localparam int      ITEMS_PER_PHASE = 72;
  localparam int      DRAIN_CYCLES    = 24;
  localparam longint  RUN_LIMIT       = 64'd400_000 * 2 * CLK_HALF;

  logic                 clk = 1'b0;
  logic                 rst_n;
  logic                 cfg_we;
  logic [CFG_IDX_W-1:0] cfg_idx;
  logic [COEF_W-1:0]    cfg_wdata;

  int send_gap_pct;
  int stall_pct;
  int sample_count;
  int coef_sets;
  int mismatch_count;
  int filt_outstanding;
  int filt_checked;

  tiir_in_if  in_ch ();
  tiir_out_if out_ch ();

  third_order_iir_xyz_filter_core dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .cfg_we    (cfg_we),
    .cfg_idx   (cfg_idx),
    .cfg_wdata (cfg_wdata)
  );

  filt_xyz_check u_filt_check (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_ch            (in_ch),
    .out_ch           (out_ch),
    .cfg_we           (cfg_we),
    .cfg_idx          (cfg_idx),
    .cfg_wdata        (cfg_wdata),
    .mismatch_count   (mismatch_count),
    .filt_outstanding (filt_outstanding),
    .filt_checked     (filt_checked)
  );

  always begin
    #CLK_HALF clk = 1'b1;
    #CLK_HALF clk = 1'b0;
  end

  // Stall the result channel at random
  always @(negedge clk) begin
    out_ch.ready <= rst_n && ($urandom_range(0, 99) >= stall_pct);
  end

  // Send one sample beat, with an optional random gap ahead of it
  task automatic push_sample(input sample_t ex, input sample_t ey, input sample_t ez);
    if ($urandom_range(0, 99) < send_gap_pct) begin
      in_ch.valid <= 1'b0;
      @(negedge clk);
      while ($urandom_range(0, 99) < send_gap_pct) @(negedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.err_x <= ex;
    in_ch.err_y <= ey;
    in_ch.err_z <= ez;
    do @(posedge clk); while (!in_ch.ready);
    @(negedge clk);
    sample_count++;
  endtask

  // Hold the sender until every pending result has come back
  task automatic drain_results();
    in_ch.valid <= 1'b0;
    do @(negedge clk); while (filt_outstanding != 0);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input coef_t value);
    cfg_we    <= 1'b1;
    cfg_idx   <= idx;
    cfg_wdata <= value;
    @(negedge clk);
  endtask

  // Load a full tap set while idle, plus a write to the unused index
  task automatic load_taps(input coef_t taps [NUM_TAPS]);
    drain_results();
    write_reg(CFG_FF_TAP0, taps[0]);
    write_reg(CFG_FF_TAP1, taps[1]);
    write_reg(CFG_FF_TAP2, taps[2]);
    write_reg(CFG_FF_TAP3, taps[3]);
    write_reg(CFG_FB_TAP1, taps[4]);
    write_reg(CFG_FB_TAP2, taps[5]);
    write_reg(CFG_FB_TAP3, taps[6]);
    write_reg(CFG_IDX_UNUSED, coef_t'($urandom));
    cfg_we <= 1'b0;
    coef_sets++;
  endtask

  // Mix full-range noise, small errors, corner values and held levels
  function automatic sample_t draw_error(sample_t prev);
    int sel;
    sel = $urandom_range(0, 99);
    if (sel < 40) begin
      return sample_t'($urandom);
    end else if (sel < 70) begin
      return sample_t'($urandom_range(0, 1 << 21)) - sample_t'(1 << 20);
    end else if (sel < 85) begin
      case ($urandom_range(0, 4))
        0:       return SAT_MAX;
        1:       return SAT_MIN;
        2:       return sample_t'(1);
        3:       return -sample_t'(1);
        default: return sample_t'(0);
      endcase
    end
    return prev;
  endfunction

  initial begin
    #RUN_LIMIT;
    $display("FAIL third_order_iir_xyz_filter_core");
    $finish;
  end

  initial begin
    coef_t      taps [NUM_TAPS];
    sample_t    last_err [NUM_FIELDS];
    coef_set_e  kind;
    idle_mode_e mode;
    int         phase;
    int         n;
    int         i;

    rst_n        = 1'b0;
    cfg_we       = 1'b0;
    cfg_idx      = '0;
    cfg_wdata    = '0;
    in_ch.valid  = 1'b0;
    in_ch.err_x  = '0;
    in_ch.err_y  = '0;
    in_ch.err_z  = '0;
    out_ch.ready = 1'b0;
    send_gap_pct = 0;
    stall_pct    = 0;
    last_err     = '{default: '0};

    repeat (RESET_CYCLES) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Reset taps: zero, corners with mixed signs, small steps
    push_sample(0, 0, 0);
    push_sample(SAT_MAX, SAT_MIN, 0);
    push_sample(SAT_MIN, SAT_MAX, 1);
    // Hold full scale so the step overshoot drives the output into its clamp
    repeat (5) push_sample(SAT_MAX, SAT_MAX, SAT_MAX);
    repeat (5) push_sample(SAT_MIN, SAT_MIN, SAT_MIN);
    push_sample(1, -32'sd1, 32'sh0001_0000);
    push_sample(0, 0, 0);

    // Extreme taps with runaway feedback, both polarities
    taps = '{COEF_MAX, COEF_MAX, COEF_MAX, COEF_MAX, COEF_MIN, COEF_MIN, COEF_MIN};
    load_taps(taps);
    push_sample(1, -32'sd1, SAT_MAX);
    push_sample(SAT_MAX, SAT_MIN, 0);
    push_sample(0, 0, 0);
    push_sample(32'sh1234_5678, -32'sh1234_5678, SAT_MIN);
    taps = '{COEF_MIN, COEF_MIN, COEF_MIN, COEF_MIN, COEF_MAX, COEF_MAX, COEF_MAX};
    load_taps(taps);
    push_sample(SAT_MIN, SAT_MAX, 1);
    push_sample(SAT_MIN, SAT_MIN, SAT_MIN);
    push_sample(-32'sd1, 1, 0);
    push_sample(SAT_MAX, 0, SAT_MAX);

    // Random phases: each tap-set kind under two idle modes
    for (phase = 0; phase < PHASES; phase++) begin
      kind = coef_set_e'((phase / 2) % 4);
      mode = idle_mode_e'(phase % 4);
      for (i = 0; i < NUM_TAPS; i++) begin
        case (kind)
          COEF_DEFAULT: taps[i] = TAP_RESET[i];
          // Small feedback keeps the poles well inside the unit circle
          COEF_STABLE:  taps[i] = (i < FF_TAPS)
                                  ? coef_t'($urandom_range(0, 1 << 28)) - coef_t'(1 << 27)
                                  : coef_t'($urandom_range(0, 1 << 29)) - coef_t'(1 << 28);
          COEF_RANDOM:  taps[i] = coef_t'($urandom);
          default: begin
            case ($urandom_range(0, 4))
              0:       taps[i] = COEF_MAX;
              1:       taps[i] = COEF_MIN;
              2:       taps[i] = COEF_ONE;
              3:       taps[i] = -COEF_ONE;
              default: taps[i] = '0;
            endcase
          end
        endcase
      end
      load_taps(taps);
      send_gap_pct = (mode == IDLE_SEND) ? 69 : (mode == IDLE_BOTH) ? 34 : 0;
      stall_pct    = (mode == IDLE_RECV) ? 69 : (mode == IDLE_BOTH) ? 34 : 0;
      for (n = 0; n < ITEMS_PER_PHASE; n++) begin
        if (n == ITEMS_PER_PHASE / 2) begin
          drain_results();
        end
        for (i = 0; i < NUM_FIELDS; i++) begin
          last_err[i] = draw_error(last_err[i]);
        end
        push_sample(last_err[0], last_err[1], last_err[2]);
      end
    end

    drain_results();
    repeat (DRAIN_CYCLES) @(negedge clk);

    $display("Covered %0d samples over %0d tap sets; %0d filtered beats checked.",
             sample_count, coef_sets + 1, filt_checked);
    $display("Idle modes none, sender gaps, receiver stalls and both; clamps in both directions.");
    if (mismatch_count == 0 && filt_outstanding == 0) begin
      $display("PASS third_order_iir_xyz_filter_core");
    end else begin
      $display("FAIL third_order_iir_xyz_filter_core");
    end
    $finish;
  end

endmodule

// ----- sim.f -----
design/tiir_pkg.sv
design/tiir_in_if.sv
design/tiir_out_if.sv
design/tiir_ctrl.sv
design/tiir_lane.sv
design/tiir_merge.sv
design/third_order_iir_xyz_filter_core.sv
design/tiir_checker.sv
sim/filt_xyz_check.sv
sim/third_order_iir_xyz_filter_core_tb.sv
